@@ rtl/park_inverse_park_transform_assert.svh @@
// Assertion macros shared by the checker of the Park transform block.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef PARK_INVERSE_PARK_TRANSFORM_ASSERT_SVH
`define PARK_INVERSE_PARK_TRANSFORM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that stays armed through reset.
`define PIPT_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pipt_pkg.sv @@
// Package for the Park and inverse Park transform block.
// Holds the fixed-point constants, register codes and shared types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pipt_pkg;

  localparam int ANGLE_BITS_DEFAULT = 12;
  localparam int DATA_WIDTH_DEFAULT = 16;

  localparam int TRIG_W      = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int PHASE_W     = 32;
  localparam int PHASE_TOP_W = 17;
  localparam int FRAC_BITS   = 15;

  localparam int SINE_STAGES  = 4;
  localparam int SCALE_STAGES = 3;

  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [14:0] SIN_B = 15'd21024;
  localparam logic [11:0] SIN_C = 12'd2320;

  localparam logic signed [TRIG_W-1:0] ROOT_TWO_THIRDS = 16'sd26755;

  localparam logic [PHASE_W-1:0] THIRD_TURN   = 32'h5555_5555;
  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic signed [CFG_W-1:0] VD_RESET = -16'sd5;
  localparam logic signed [CFG_W-1:0] VQ_RESET = 16'sd896;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VD_COMMAND = 1'b0,
    REG_VQ_COMMAND = 1'b1
  } cfg_reg_t;

  typedef logic signed [TRIG_W-1:0] trig_t;

endpackage

`default_nettype wire

@@ rtl/pipt_sine.sv @@
// Four-stage pipelined Q1.15 sine from the top 17 bits of a 32-bit phase.
// Uses pipt_pkg for the polynomial constants and the trig_t type.
`timescale 1ns / 1ps
`default_nettype none

module pipt_sine import pipt_pkg::*; (
  input  logic                   clk,
  input  logic [SINE_STAGES-1:0] en,
  input  logic [PHASE_TOP_W-1:0] phase,
  output trig_t                  sin_val
);

  localparam int X_W    = TRIG_W;
  localparam int PROD_W = 2 * X_W;
  localparam logic [X_W-1:0] ONE_Q15 = X_W'(1) << FRAC_BITS;

  logic [1:0]          quad;
  logic [FRAC_BITS-1:0] x_frac;
  logic [X_W-1:0]      x_nxt;
  logic [PROD_W-1:0]   xx;
  logic [PROD_W-1:0]   cx;
  logic [PROD_W-1:0]   tx;
  logic [PROD_W-1:0]   ty;
  logic [X_W-1:0]      y;
  logic [X_W-2:0]      y_cap;

  logic [X_W-1:0]      x1_r, x2_r, x3_r;
  logic [X_W-1:0]      sq1_r, sq2_r;
  logic [X_W-2:0]      t1_r;
  logic [X_W-1:0]      t2_r;
  logic                neg1_r, neg2_r, neg3_r;
  trig_t               sin_r;

  // Odd quadrants mirror the fraction so the polynomial always sees 0..pi/2.
  always_comb begin
    quad   = phase[PHASE_TOP_W-1 -: 2];
    x_frac = phase[FRAC_BITS-1:0];
    x_nxt  = quad[0] ? (ONE_Q15 - X_W'(x_frac)) : X_W'(x_frac);
    xx     = PROD_W'(x_nxt) * PROD_W'(x_nxt);
    cx     = PROD_W'(SIN_C) * PROD_W'(sq1_r);
    tx     = PROD_W'(t1_r) * PROD_W'(sq2_r);
    ty     = PROD_W'(t2_r) * PROD_W'(x3_r);
    y      = X_W'(ty >> FRAC_BITS);
    y_cap  = y[X_W-1] ? '1 : y[X_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_r   <= x_nxt;
      sq1_r  <= X_W'(xx >> FRAC_BITS);
      neg1_r <= quad[1];
    end
    if (en[1]) begin
      x2_r   <= x1_r;
      sq2_r  <= sq1_r;
      t1_r   <= SIN_B - (X_W-1)'(cx >> FRAC_BITS);
      neg2_r <= neg1_r;
    end
    if (en[2]) begin
      x3_r   <= x2_r;
      t2_r   <= SIN_A - X_W'(tx >> FRAC_BITS);
      neg3_r <= neg2_r;
    end
    if (en[3]) begin
      sin_r <= neg3_r ? -trig_t'({1'b0, y_cap}) : trig_t'({1'b0, y_cap});
    end
  end

  assign sin_val = sin_r;

endmodule

`default_nettype wire

@@ rtl/pipt_scale.sv @@
// Three-stage output scaling: sum with rounding, sqrt(2/3) multiply, rounding and saturation.
// Uses pipt_pkg for the scale constant and fraction width.
`timescale 1ns / 1ps
`default_nettype none

module pipt_scale import pipt_pkg::*; #(
  parameter int IN_W  = 32,
  parameter int OUT_W = DATA_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic [SCALE_STAGES-1:0]  en,
  input  logic signed [IN_W-1:0]   term_a,
  input  logic signed [IN_W-1:0]   term_b,
  input  logic signed [IN_W-1:0]   term_c,
  output logic signed [OUT_W-1:0]  result
);

  localparam int SUM_W = IN_W + 2;
  localparam int SH_W  = SUM_W - FRAC_BITS;
  localparam int MUL_W = SH_W + TRIG_W;
  localparam int RES_W = MUL_W - FRAC_BITS;
  localparam int EXT_W = (RES_W > OUT_W) ? RES_W : OUT_W;

  localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [MUL_W-1:0] MUL_HALF = MUL_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0] SAT_HI =
    {{(EXT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [MUL_W-1:0] rnd;
  logic signed [RES_W-1:0] res;
  logic signed [EXT_W-1:0] ext;

  logic signed [SH_W-1:0]  sh_r;
  logic signed [MUL_W-1:0] mul_r;
  logic signed [OUT_W-1:0] result_r;

  always_comb begin
    sum_nxt = SUM_W'(term_a) + SUM_W'(term_b) + SUM_W'(term_c) + SUM_HALF;
    rnd     = mul_r + MUL_HALF;
    res     = rnd[MUL_W-1:FRAC_BITS];
    ext     = EXT_W'(res);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sh_r <= sum_nxt[SUM_W-1:FRAC_BITS];
    end
    if (en[1]) begin
      mul_r <= MUL_W'(sh_r) * MUL_W'(ROOT_TWO_THIRDS);
    end
    if (en[2]) begin
      if (ext > SAT_HI) begin
        result_r <= SAT_HI[OUT_W-1:0];
      end else if (ext < SAT_LO) begin
        result_r <= SAT_LO[OUT_W-1:0];
      end else begin
        result_r <= ext[OUT_W-1:0];
      end
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire

@@ rtl/park_inverse_park_transform.sv @@
// Top level of the power-invariant Park and inverse Park transform pipeline.
// Uses pipt_pkg, pipt_sine and pipt_scale.
//
// Channel  Dir  Payload                                         Handshake
// in       in   phase_u_current, phase_v_current, elec_angle    in_valid / in_stall
// out      out  d_current, q_current, u/v/w_voltage             out_valid / out_stall
// cfg      in   cfg_index, cfg_data                             cfg_wr_en
//
// One item enters per cycle while in_stall is low; with no stall its result passes, in order,
// the input register, the four-stage sine polynomial, one product stage and the
// three-stage output scaling before it shows at the output.
// Synchronous reset empties the pipeline and loads the commands with -5 and 896.
// Only stages that hold an item and cannot move stall, so bubbles close up behind
// a waiting result and new items are still taken.
`timescale 1ns / 1ps
`default_nettype none

module park_inverse_park_transform import pipt_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_phase_u_current,
  input  logic signed [DATA_WIDTH-1:0] in_phase_v_current,
  input  logic [ANGLE_BITS-1:0]        in_elec_angle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_d_current,
  output logic signed [DATA_WIDTH-1:0] out_q_current,
  output logic signed [DATA_WIDTH-1:0] out_u_voltage,
  output logic signed [DATA_WIDTH-1:0] out_v_voltage,
  output logic signed [DATA_WIDTH-1:0] out_w_voltage,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data
);

  localparam int NSTG        = SINE_STAGES + SCALE_STAGES + 2;
  localparam int PROD_STG    = SINE_STAGES + 1;
  localparam int W_W         = DATA_WIDTH + 2;
  localparam int CUR_PROD_W  = W_W + TRIG_W;
  localparam int VOLT_PROD_W = CFG_W + TRIG_W;
  localparam int NTRIG       = 6;

  localparam int S0 = 0;
  localparam int C0 = 1;
  localparam int SM = 2;
  localparam int CM = 3;
  localparam int SP = 4;
  localparam int CP = 5;

  localparam logic [PHASE_W-1:0] PH_OFS [NTRIG] = '{
    PHASE_W'(0),
    QUARTER_TURN,
    PHASE_W'(0) - THIRD_TURN,
    QUARTER_TURN - THIRD_TURN,
    THIRD_TURN,
    QUARTER_TURN + THIRD_TURN
  };

  logic [NSTG-1:0]              en;
  logic [NSTG-1:0]              vld_r;
  logic [NSTG-1:0]              vld_nxt;

  logic signed [CFG_W-1:0]      vd_r;
  logic signed [CFG_W-1:0]      vq_r;

  logic [PHASE_W-1:0]           p0;
  logic [PHASE_W-1:0]           ph_sum [NTRIG];
  logic [PHASE_TOP_W-1:0]       ph_r   [NTRIG];
  trig_t                        trig   [NTRIG];

  logic signed [W_W-1:0]        w_nxt;
  logic signed [DATA_WIDTH-1:0] u_r [SINE_STAGES+1];
  logic signed [DATA_WIDTH-1:0] v_r [SINE_STAGES+1];
  logic signed [W_W-1:0]        w_r [SINE_STAGES+1];

  logic signed [CUR_PROD_W-1:0]  cur_prod_r  [NTRIG];
  logic signed [VOLT_PROD_W-1:0] volt_prod_r [NTRIG];

  // Handshake: a stage may load when it is empty or when the stage after it moves.
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = (en & {vld_r[NSTG-2:0], in_valid}) | (~en & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= VD_RESET;
      vq_r <= VQ_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_VD_COMMAND: vd_r <= cfg_data;
        REG_VQ_COMMAND: vq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    p0    = {in_elec_angle, {(PHASE_W - ANGLE_BITS){1'b0}}};
    w_nxt = -(W_W'(in_phase_u_current) + W_W'(in_phase_v_current));
    for (int j = 0; j < NTRIG; j++) begin
      ph_sum[j] = p0 + PH_OFS[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u_r[0] <= in_phase_u_current;
      v_r[0] <= in_phase_v_current;
      w_r[0] <= w_nxt;
      for (int j = 0; j < NTRIG; j++) begin
        ph_r[j] <= ph_sum[j][PHASE_W-1 -: PHASE_TOP_W];
      end
    end
    for (int k = 1; k <= SINE_STAGES; k++) begin
      if (en[k]) begin
        u_r[k] <= u_r[k-1];
        v_r[k] <= v_r[k-1];
        w_r[k] <= w_r[k-1];
      end
    end
  end

  for (genvar j = 0; j < NTRIG; j++) begin : g_sine
    pipt_sine u_sine (
      .clk     (clk),
      .en      (en[SINE_STAGES:1]),
      .phase   (ph_r[j]),
      .sin_val (trig[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en[PROD_STG]) begin
      cur_prod_r[0] <= CUR_PROD_W'(trig[C0]) * CUR_PROD_W'(u_r[SINE_STAGES]);
      cur_prod_r[1] <= CUR_PROD_W'(trig[CM]) * CUR_PROD_W'(v_r[SINE_STAGES]);
      cur_prod_r[2] <= CUR_PROD_W'(trig[CP]) * CUR_PROD_W'(w_r[SINE_STAGES]);
      cur_prod_r[3] <= -(CUR_PROD_W'(trig[S0]) * CUR_PROD_W'(u_r[SINE_STAGES]));
      cur_prod_r[4] <= -(CUR_PROD_W'(trig[SM]) * CUR_PROD_W'(v_r[SINE_STAGES]));
      cur_prod_r[5] <= -(CUR_PROD_W'(trig[SP]) * CUR_PROD_W'(w_r[SINE_STAGES]));
      volt_prod_r[0] <= VOLT_PROD_W'(trig[C0]) * VOLT_PROD_W'(vd_r);
      volt_prod_r[1] <= -(VOLT_PROD_W'(trig[S0]) * VOLT_PROD_W'(vq_r));
      volt_prod_r[2] <= VOLT_PROD_W'(trig[CM]) * VOLT_PROD_W'(vd_r);
      volt_prod_r[3] <= -(VOLT_PROD_W'(trig[SM]) * VOLT_PROD_W'(vq_r));
      volt_prod_r[4] <= VOLT_PROD_W'(trig[CP]) * VOLT_PROD_W'(vd_r);
      volt_prod_r[5] <= -(VOLT_PROD_W'(trig[SP]) * VOLT_PROD_W'(vq_r));
    end
  end

  pipt_scale #(.IN_W(CUR_PROD_W), .OUT_W(DATA_WIDTH)) u_scale_d (
    .clk    (clk),
    .en     (en[NSTG-1:PROD_STG+1]),
    .term_a (cur_prod_r[0]),
    .term_b (cur_prod_r[1]),
    .term_c (cur_prod_r[2]),
    .result (out_d_current)
  );

  pipt_scale #(.IN_W(CUR_PROD_W), .OUT_W(DATA_WIDTH)) u_scale_q (
    .clk    (clk),
    .en     (en[NSTG-1:PROD_STG+1]),
    .term_a (cur_prod_r[3]),
    .term_b (cur_prod_r[4]),
    .term_c (cur_prod_r[5]),
    .result (out_q_current)
  );

  pipt_scale #(.IN_W(VOLT_PROD_W), .OUT_W(DATA_WIDTH)) u_scale_u (
    .clk    (clk),
    .en     (en[NSTG-1:PROD_STG+1]),
    .term_a (volt_prod_r[0]),
    .term_b (volt_prod_r[1]),
    .term_c ('0),
    .result (out_u_voltage)
  );

  pipt_scale #(.IN_W(VOLT_PROD_W), .OUT_W(DATA_WIDTH)) u_scale_v (
    .clk    (clk),
    .en     (en[NSTG-1:PROD_STG+1]),
    .term_a (volt_prod_r[2]),
    .term_b (volt_prod_r[3]),
    .term_c ('0),
    .result (out_v_voltage)
  );

  pipt_scale #(.IN_W(VOLT_PROD_W), .OUT_W(DATA_WIDTH)) u_scale_w (
    .clk    (clk),
    .en     (en[NSTG-1:PROD_STG+1]),
    .term_a (volt_prod_r[4]),
    .term_b (volt_prod_r[5]),
    .term_c ('0),
    .result (out_w_voltage)
  );

endmodule

`default_nettype wire

@@ rtl/pipt_checker.sv @@
// Port-level checker for the Park transform top level, attached by bind.
// Uses pipt_pkg and the macros in park_inverse_park_transform_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "park_inverse_park_transform_assert.svh"

module pipt_checker import pipt_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DATA_WIDTH-1:0] out_d_current,
  input logic signed [DATA_WIDTH-1:0] out_q_current,
  input logic signed [DATA_WIDTH-1:0] out_u_voltage,
  input logic signed [DATA_WIDTH-1:0] out_v_voltage,
  input logic signed [DATA_WIDTH-1:0] out_w_voltage
);

  logic [5*DATA_WIDTH-1:0] out_bundle;

  assign out_bundle = {out_d_current, out_q_current, out_u_voltage,
                       out_v_voltage, out_w_voltage};

  // An accepted item must reach the output when out_stall stays low through s_free_flow.
  sequence s_free_flow;
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall;
  endsequence

  `PIPT_ASSERT_RESET(a_reset_empties, !rst_n, !out_valid, "output valid after reset")
  `PIPT_ASSERT_SAME(a_stall_source, in_stall, out_valid && out_stall, "input stall without cause")
  `PIPT_ASSERT_NEXT(a_latency, s_free_flow, out_valid, "item late through free pipeline")
  `PIPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bundle), "result moved")

endmodule

bind park_inverse_park_transform pipt_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pipt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_d_current (out_d_current),
  .out_q_current (out_q_current),
  .out_u_voltage (out_u_voltage),
  .out_v_voltage (out_v_voltage),
  .out_w_voltage (out_w_voltage)
);

`default_nettype wire

@@ test/park_inverse_park_checker.sv @@
// Checker for the Park and inverse Park transform block: predicts each result
// from the accepted items and the command registers, and compares it with the output.
// Depends on pipt_pkg for the register codes.
`timescale 1ns / 1ps

module park_inverse_park_checker import pipt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_phase_u_current,
  input  logic signed [15:0] in_phase_v_current,
  input  logic [11:0]        in_elec_angle,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_d_current,
  input  logic signed [15:0] out_q_current,
  input  logic signed [15:0] out_u_voltage,
  input  logic signed [15:0] out_v_voltage,
  input  logic signed [15:0] out_w_voltage,
  input  logic               cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 pending,
  output int                 checked
);

  localparam longint POLY_A = 51472;
  localparam longint POLY_B = 21024;
  localparam longint POLY_C = 2320;
  localparam longint SQRT_TWO_THIRDS = 26755;
  localparam bit [31:0] PHASE_THIRD = 32'h5555_5555;
  localparam bit [31:0] PHASE_QUARTER = 32'h4000_0000;
  localparam logic signed [15:0] VD_AT_RESET = -16'sd5;
  localparam logic signed [15:0] VQ_AT_RESET = 16'sd896;

  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] q;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic signed [15:0] w;
  } phase_frame_t;

  phase_frame_t pending_frames[$];
  logic signed [15:0] vd_cmd;
  logic signed [15:0] vq_cmd;

  function automatic longint sine_q15(bit [31:0] ph);
    longint x, x2, t, y;
    x = ph[29:15];
    if (ph[30]) x = 32768 - x;
    x2 = (x * x) >>> 15;
    t = (POLY_C * x2) >>> 15;
    t = POLY_B - t;
    t = (t * x2) >>> 15;
    t = POLY_A - t;
    y = (t * x) >>> 15;
    if (y > 32767) y = 32767;
    return ph[31] ? -y : y;
  endfunction

  function automatic longint round_q15(longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic logic signed [15:0] scale_clamp(longint sum);
    longint r;
    r = round_q15(round_q15(sum) * SQRT_TWO_THIRDS);
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  function automatic phase_frame_t predict_phase_frame(
    logic signed [15:0] iu_in, logic signed [15:0] iv_in, logic [11:0] angle,
    logic signed [15:0] vd_in, logic signed [15:0] vq_in);
    phase_frame_t f;
    longint iu, iv, iw, vd, vq, c0, cm, cp, s0, sm, sp;
    bit [31:0] p0, pm, pp;
    iu = iu_in;
    iv = iv_in;
    iw = -(iu + iv);
    vd = vd_in;
    vq = vq_in;
    p0 = {angle, 20'd0};
    pm = p0 - PHASE_THIRD;
    pp = p0 + PHASE_THIRD;
    c0 = sine_q15(p0 + PHASE_QUARTER);
    cm = sine_q15(pm + PHASE_QUARTER);
    cp = sine_q15(pp + PHASE_QUARTER);
    s0 = sine_q15(p0);
    sm = sine_q15(pm);
    sp = sine_q15(pp);
    f.d = scale_clamp(c0 * iu + cm * iv + cp * iw);
    f.q = scale_clamp(-(s0 * iu) - sm * iv - sp * iw);
    f.u = scale_clamp(c0 * vd - s0 * vq);
    f.v = scale_clamp(cm * vd - sm * vq);
    f.w = scale_clamp(cp * vd - sp * vq);
    return f;
  endfunction

  always @(posedge clk) begin
    phase_frame_t got, want;
    if (!rst_n) begin
      vd_cmd = VD_AT_RESET;
      vq_cmd = VQ_AT_RESET;
      mismatches = 0;
      checked = 0;
      pending_frames.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_d_current, out_q_current, out_u_voltage, out_v_voltage, out_w_voltage};
        if (pending_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result d %0d q %0d u %0d v %0d w %0d at %0t.",
                     got.d, got.q, got.u, got.v, got.w, $realtime);
        end else begin
          want = pending_frames.pop_front();
          checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result %0d differs: expected d %0d q %0d u %0d v %0d w %0d, ",
                       checked, want.d, want.q, want.u, want.v, want.w,
                       "got d %0d q %0d u %0d v %0d w %0d.",
                       got.d, got.q, got.u, got.v, got.w);
          end
        end
      end
      if (in_valid && !in_stall)
        pending_frames.push_back(predict_phase_frame(in_phase_u_current,
          in_phase_v_current, in_elec_angle, vd_cmd, vq_cmd));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_VD_COMMAND: vd_cmd = cfg_data;
          REG_VQ_COMMAND: vq_cmd = cfg_data;
          default: ;
        endcase
      end
    end
    pending = pending_frames.size();
  end

endmodule

@@ test/tb_park_inverse_park_transform.sv @@
// Top of the testbench for the Park and inverse Park transform block.
// Drives directed and random items under several command settings with bursty input
// and output stalls; uses pipt_pkg and park_inverse_park_checker.
`timescale 1ns / 1ps

module tb_park_inverse_park_transform import pipt_pkg::*;;

  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_phase_u_current = '0;
  logic signed [15:0] in_phase_v_current = '0;
  logic [11:0] in_elec_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_d_current, out_q_current;
  logic signed [15:0] out_u_voltage, out_v_voltage, out_w_voltage;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_VD_COMMAND;
  logic [15:0] cfg_data = '0;

  int mismatches, pending, checked;
  int stall_pct = 0;
  bit hold_req = 0;
  int items_sent = 0;
  int settings_used = 1;

  logic signed [15:0] dir_u [14];
  logic signed [15:0] dir_v [14];
  logic [11:0] dir_a [14];
  logic signed [15:0] phase_vd [PHASES];
  logic signed [15:0] phase_vq [PHASES];
  int phase_stall [PHASES];
  int phase_gap [PHASES];

  always #2 clk = ~clk;

  park_inverse_park_transform uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_phase_u_current(in_phase_u_current), .in_phase_v_current(in_phase_v_current),
    .in_elec_angle(in_elec_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_d_current(out_d_current), .out_q_current(out_q_current),
    .out_u_voltage(out_u_voltage), .out_v_voltage(out_v_voltage),
    .out_w_voltage(out_w_voltage),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  park_inverse_park_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_phase_u_current(in_phase_u_current), .in_phase_v_current(in_phase_v_current),
    .in_elec_angle(in_elec_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_d_current(out_d_current), .out_q_current(out_q_current),
    .out_u_voltage(out_u_voltage), .out_v_voltage(out_v_voltage),
    .out_w_voltage(out_w_voltage),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  function automatic logic signed [15:0] pick_current();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    if (sel < 5) return 16'($urandom_range(0, 2047)) - 16'sd1024;
    return 16'($urandom);
  endfunction

  function automatic logic [11:0] pick_angle();
    if ($urandom_range(0, 4) == 0)
      return 12'($urandom_range(0, 3) * 1024 + $urandom_range(0, 2) - 1);
    return 12'($urandom);
  endfunction

  task automatic send_item(input logic signed [15:0] iu, input logic signed [15:0] iv,
                           input logic [11:0] angle);
    in_valid <= 1'b1;
    in_phase_u_current <= iu;
    in_phase_v_current <= iv;
    in_elec_angle <= angle;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_commands(input logic signed [15:0] vd, input logic signed [15:0] vq);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_VD_COMMAND;
    cfg_data <= vd;
    @(negedge clk);
    cfg_index <= REG_VQ_COMMAND;
    cfg_data <= vq;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  // Receiver: random stall runs, with a long hold on request so the pipeline backs up.
  initial begin
    int run;
    bit held;
    held = 0;
    forever begin
      if (hold_req && !held) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(1, 100) <= stall_pct);
        run = $urandom_range(1, 6);
        repeat (run) @(negedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int sent, burst, gap;
    dir_u = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sd256, 16'sh7fff,
              16'sh8000, -16'sd1, 16'sd1, 16'sd0, 16'sh8000, 16'sd0, 16'sd12345};
    dir_v = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, -16'sd256, 16'sh7fff,
              16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sh8000, -16'sd6789};
    dir_a = '{12'd0, 12'd0, 12'd1024, 12'd2048, 12'd3072, 12'd4095, 12'd683,
              12'd1365, 12'd2731, 12'd1, 12'd2047, 12'd3413, 12'd512, 12'd2900};
    phase_vd = '{16'sh7fff, 16'sh8000, 16'sd0, 16'($urandom), 16'sh8000, -16'sd5};
    phase_vq = '{16'sh8000, 16'sh7fff, 16'sd0, 16'($urandom), 16'sh8000, 16'sd896};
    phase_stall = '{30, 70, 0, 50, 10, 90};
    phase_gap = '{4, 0, 0, 8, 2, 3};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < 14; i++) send_item(dir_u[i], dir_v[i], dir_a[i]);
    wait_idle();
    for (int s = 0; s < 2; s++) begin
      if (s == 0) load_commands(16'sh7fff, 16'sh8000);
      else load_commands(16'sh8000, 16'sh7fff);
      for (int k = 0; k < 4; k++)
        send_item(pick_current(), pick_current(), 12'((s * 4 + k) * 512));
      wait_idle();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      load_commands(phase_vd[ph], phase_vq[ph]);
      stall_pct = phase_stall[ph];
      if (ph == 2) hold_req = 1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          send_item(pick_current(), pick_current(), pick_angle());
          sent++;
        end
        gap = $urandom_range(0, phase_gap[ph]);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      wait_idle();
    end

    $display("Sent %0d items under %0d command settings and checked %0d results,",
             items_sent, settings_used, checked);
    $display("with bursty input, random output stalls and one %0d-cycle output hold.",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pipt_pkg.sv
rtl/pipt_sine.sv
rtl/pipt_scale.sv
rtl/park_inverse_park_transform.sv
rtl/pipt_checker.sv
test/park_inverse_park_checker.sv
test/tb_park_inverse_park_transform.sv
